// ===== design/orl_pkg.sv =====
// Shared types, codes and the key compare helper of the ordered record list.
package orl_pkg;

    localparam int CAPACITY = 128;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FIND   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_NOKEY = 2'd3
    } t_status;

    typedef struct packed {
        logic [63:0] key_low;
        logic [7:0]  key_high;
        logic [63:0] name_first;
        logic [63:0] name_second;
        logic [23:0] name_third;
        logic [7:0]  age;
    } t_rec;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  position;
        logic [63:0] key_low;
        logic [7:0]  key_high;
        logic [63:0] name_first;
        logic [63:0] name_second;
        logic [23:0] name_third;
        logic [7:0]  age;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [7:0]  found_position;
        logic [63:0] out_key_low;
        logic [7:0]  out_key_high;
        logic [63:0] out_name_first;
        logic [63:0] out_name_second;
        logic [23:0] out_name_third;
        logic [7:0]  out_age;
        logic [7:0]  list_length;
    } t_out;

    // Keys compare as strings: every character after the first zero is dropped.
    function automatic logic [71:0] key_canon(input logic [63:0] lo, input logic [7:0] hi);
        logic [63:0] out_lo;
        logic        ended;
        out_lo = '0;
        ended  = 1'b0;
        for (int b = 0; b < 8; b++) begin
            if (lo[8*b +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                out_lo[8*b +: 8] = lo[8*b +: 8];
            end
        end
        return {(ended ? 8'd0 : hi), out_lo};
    endfunction

endpackage

// ===== design/ordered_record_list.sv =====
// Ordered record list with one shared record memory walked by a small sequencer.
//
//  channel | direction | handshake               | beat
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | one request (t_in)
//  out     | output    | o_out_valid / i_out_stall | one result (t_out)
//
// Every memory step on the single read and write port is a read state and then a state that
// uses the registered data. Insert moves the records from p to the end up, last first, then puts;
// append puts at once; delete moves the records above p down; read and find walk; errors end at once.
// Reset clears the length and the control state only; the record memory is not cleared.
// A request is taken while the previous result still waits in the output register; a
// finished request waits in its last state until that register is free.
module ordered_record_list #(
    parameter int CAPACITY = orl_pkg::CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  orl_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output orl_pkg::t_out o_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_PUT,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [AW-1:0]    r_idx;
    logic             r_first;
    orl_pkg::t_cmd    r_cmd;
    orl_pkg::t_rec    r_req_rec;
    logic [71:0]      r_qkey;
    orl_pkg::t_status r_res_status;
    logic [7:0]       r_res_pos;
    orl_pkg::t_rec    r_res_rec;
    orl_pkg::t_out    r_out;
    logic             r_out_valid;

    orl_pkg::t_rec    r_mem [CAPACITY];
    orl_pkg::t_rec    r_rd_data;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    orl_pkg::t_rec    w_wdata;
    logic             w_full;
    logic             w_pos_ok;
    logic             w_more;
    logic             w_key_hit;
    orl_pkg::t_rec    w_in_rec;

    t_state           n_state;
    logic [AW-1:0]    n_idx;
    orl_pkg::t_status n_res_status;
    logic [7:0]       n_res_pos;

    assign w_full    = 9'(r_count) >= 9'(CAPACITY);
    assign w_pos_ok  = (i_in.position != 8'd0) && (9'(i_in.position) <= 9'(r_count));
    assign w_more    = (9'(r_idx) + 9'd1) < 9'(r_count);
    assign w_key_hit = orl_pkg::key_canon(r_rd_data.key_low, r_rd_data.key_high) == r_qkey;

    assign w_in_rec.key_low     = i_in.key_low;
    assign w_in_rec.key_high    = i_in.key_high;
    assign w_in_rec.name_first  = i_in.name_first;
    assign w_in_rec.name_second = i_in.name_second;
    assign w_in_rec.name_third  = i_in.name_third;
    assign w_in_rec.age         = i_in.age;

    // A request taken in the idle state either ends at once with an error or starts its walk (append: its put).
    always_comb begin
        n_state      = S_DONE;
        n_idx        = '0;
        n_res_status = orl_pkg::ST_OK;
        n_res_pos    = 8'd0;
        unique case (i_in.cmd)
            orl_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_res_status = orl_pkg::ST_FULL;
                end else if (!w_pos_ok) begin
                    n_res_status = orl_pkg::ST_RANGE;
                end else begin
                    n_idx     = AW'(r_count - CW'(1));
                    n_res_pos = i_in.position;
                    n_state   = S_RD;
                end
            end
            orl_pkg::CMD_APPEND: begin
                if (w_full) begin
                    n_res_status = orl_pkg::ST_FULL;
                end else begin
                    n_idx     = AW'(r_count);
                    n_res_pos = 8'(9'(r_count) + 9'd1);
                    n_state   = S_PUT;
                end
            end
            orl_pkg::CMD_DELETE, orl_pkg::CMD_READ: begin
                if (!w_pos_ok) begin
                    n_res_status = orl_pkg::ST_RANGE;
                end else begin
                    n_idx     = AW'(i_in.position - 8'd1);
                    n_res_pos = i_in.position;
                    n_state   = S_RD;
                end
            end
            orl_pkg::CMD_FIND: begin
                if (r_count == '0) begin
                    n_res_status = orl_pkg::ST_NOKEY;
                end else begin
                    n_state = S_RD;
                end
            end
            default: begin
                n_res_status = orl_pkg::ST_RANGE;
            end
        endcase
    end

    // Write port: shifts copy the record just read one place up or down; puts store the request.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_rd_data;
        unique case (r_state)
            S_WR: begin
                if (r_cmd == orl_pkg::CMD_INSERT) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx + AW'(1);
                end else if (r_cmd == orl_pkg::CMD_DELETE && !r_first) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx - AW'(1);
                end
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_wdata = r_req_rec;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            // In the done state the output register is reloaded whenever it drains.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd        <= orl_pkg::t_cmd'(i_in.cmd);
                        r_req_rec    <= w_in_rec;
                        r_qkey       <= orl_pkg::key_canon(i_in.key_low, i_in.key_high);
                        r_first      <= 1'b1;
                        r_res_status <= n_res_status;
                        r_res_pos    <= n_res_pos;
                        r_res_rec    <= '0;
                        r_idx        <= n_idx;
                        r_state      <= n_state;
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    unique case (r_cmd)
                        orl_pkg::CMD_INSERT: begin
                            // The shift ends once the record at the insert slot has moved up.
                            if ((9'(r_idx) + 9'd1) == 9'(r_res_pos)) begin
                                r_state <= S_PUT;
                            end else begin
                                r_idx   <= r_idx - AW'(1);
                                r_state <= S_RD;
                            end
                        end
                        orl_pkg::CMD_DELETE: begin
                            r_first <= 1'b0;
                            if (r_first) begin
                                r_res_rec <= r_rd_data;
                            end
                            if (w_more) begin
                                r_idx   <= r_idx + AW'(1);
                                r_state <= S_RD;
                            end else begin
                                r_count <= r_count - CW'(1);
                                r_state <= S_DONE;
                            end
                        end
                        orl_pkg::CMD_READ: begin
                            r_res_rec <= r_rd_data;
                            r_state   <= S_DONE;
                        end
                        orl_pkg::CMD_FIND: begin
                            if (w_key_hit) begin
                                r_res_rec <= r_rd_data;
                                r_res_pos <= 8'(9'(r_idx) + 9'd1);
                                r_state   <= S_DONE;
                            end else if (w_more) begin
                                r_idx   <= r_idx + AW'(1);
                                r_state <= S_RD;
                            end else begin
                                r_res_status <= orl_pkg::ST_NOKEY;
                                r_state      <= S_DONE;
                            end
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_PUT: begin
                    r_count   <= r_count + CW'(1);
                    r_res_rec <= r_req_rec;
                    r_state   <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.status          <= r_res_status;
                        r_out.found_position  <= r_res_pos;
                        r_out.out_key_low     <= r_res_rec.key_low;
                        r_out.out_key_high    <= r_res_rec.key_high;
                        r_out.out_name_first  <= r_res_rec.name_first;
                        r_out.out_name_second <= r_res_rec.name_second;
                        r_out.out_name_third  <= r_res_rec.name_third;
                        r_out.out_age         <= r_res_rec.age;
                        r_out.list_length     <= 8'(r_count);
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'(r_count) <= 9'(CAPACITY))
        else $error("list length beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == CW'($past(r_count) + CW'(1)))
        || (r_count == CW'($past(r_count) - CW'(1))))
        else $error("list length moved by more than one");

    a_error_zero_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != orl_pkg::ST_OK)) |-> (o_out.found_position == 8'd0))
        else $error("error result carries a position");

endmodule
